/* rtl/core/fcd_pkg.sv */
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared constants, command codes and controller/datapath structs for the
// graph square detector.
// ----------------------------------------------------------------------------
`default_nettype none

package fcd_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int CMD_W            = 2;
  localparam int VTX_W            = 7;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_cnt;   // latch vertex count, rewind row counter
    logic load_edge;  // latch edge endpoints
    logic clr_wr;     // zero the row at j
    logic edge_rd_a;  // read row a
    logic edge_wr_a;  // write row a, read row b
    logic edge_wr_b;  // write row b
    logic q_start;    // rewind i, drop hit flag
    logic rd_i;       // read row i
    logic ld_i;       // capture row i, j = i + 1
    logic rd_j;       // read row j
    logic next_j;     // advance j
    logic next_i;     // advance i
    logic set_hit;    // record a square
    logic res_load;   // move hit flag to the result register
  } fcd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;   // incoming vertex count is zero
    logic edge_ok;    // incoming edge is in range and no self-loop
    logic few_vtx;    // fewer than two active vertices
    logic j_last;     // j is the last active row
    logic i_last;     // i is the last first-vertex of a pair
    logic pair_hit;   // rows i and j share two or more neighbors
  } fcd_sts_t;

endpackage

`default_nettype wire

/* rtl/core/fcd_if.sv */
// ----------------------------------------------------------------------------
// fcd_if
// Valid/ready channel interfaces for the request and result sides.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcd_in_if import fcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [VTX_W-1:0] vertex_count;
  logic [VTX_W-1:0] vertex_a;
  logic [VTX_W-1:0] vertex_b;

  modport source (output valid, command, vertex_count, vertex_a, vertex_b, input ready);
  modport sink   (input valid, command, vertex_count, vertex_a, vertex_b, output ready);
  modport mon    (input valid, ready, command, vertex_count, vertex_a, vertex_b);
endinterface

interface fcd_out_if ();
  logic valid;
  logic ready;
  logic has_square;

  modport source (output valid, has_square, input ready);
  modport sink   (input valid, has_square, output ready);
  modport mon    (input valid, ready, has_square);
endinterface

`default_nettype wire

/* rtl/core/fcd_ram.sv */
// ----------------------------------------------------------------------------
// fcd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_ram import fcd_pkg::*; #(
  parameter int WIDTH = MAX_VERTICES_DEF,
  parameter int DEPTH = MAX_VERTICES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fcd_dp.sv */
// ----------------------------------------------------------------------------
// fcd_dp
// Datapath: adjacency RAM, vertex count, row counters, row-i register,
// common-neighbor test and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_dp import fcd_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  fcd_cmd_t         cmd,
  output fcd_sts_t         sts,
  input  logic [VTX_W-1:0] vertex_count,
  input  logic [VTX_W-1:0] vertex_a,
  input  logic [VTX_W-1:0] vertex_b,
  output logic             has_square
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int EW = (CW > VTX_W) ? CW : VTX_W;

  logic [CW-1:0]           active;
  logic [AW-1:0]           a_idx;
  logic [AW-1:0]           b_idx;
  logic [AW-1:0]           i;
  logic [AW-1:0]           j;
  logic [MAX_VERTICES-1:0] row_i;
  logic                    hit;
  logic                    res;

  logic [EW-1:0]           cnt_ext;
  logic [EW-1:0]           a_ext;
  logic [EW-1:0]           b_ext;
  logic [EW-1:0]           n_ext;
  logic [EW-1:0]           a_m1;
  logic [EW-1:0]           b_m1;
  logic [CW-1:0]           cnt_sat;
  logic [MAX_VERTICES-1:0] one_row;
  logic [MAX_VERTICES-1:0] common;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [MAX_VERTICES-1:0] ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [MAX_VERTICES-1:0] ram_rdata;

  assign cnt_ext = EW'(vertex_count);
  assign a_ext   = EW'(vertex_a);
  assign b_ext   = EW'(vertex_b);
  assign n_ext   = EW'(active);
  assign a_m1    = a_ext - EW'(1);
  assign b_m1    = b_ext - EW'(1);
  assign cnt_sat = (cnt_ext > EW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(cnt_ext);
  assign one_row = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

  // Two common neighbors: clearing the lowest set bit leaves something.
  assign common = ram_rdata & row_i;

  assign sts.cnt_zero = (vertex_count == '0);
  assign sts.edge_ok  = (vertex_a != '0) && (vertex_b != '0) && (a_ext <= n_ext)
                        && (b_ext <= n_ext) && (vertex_a != vertex_b);
  assign sts.few_vtx  = (active < CW'(2));
  assign sts.j_last   = (CW'(j) == active - CW'(1));
  assign sts.i_last   = (CW'(i) == active - CW'(2));
  assign sts.pair_hit = |(common & (common - MAX_VERTICES'(1)));

  assign ram_we    = cmd.clr_wr | cmd.edge_wr_a | cmd.edge_wr_b;
  assign ram_waddr = cmd.clr_wr ? j : (cmd.edge_wr_a ? a_idx : b_idx);
  assign ram_wdata = cmd.clr_wr    ? '0 :
                     cmd.edge_wr_a ? (ram_rdata | (one_row << b_idx)) :
                                     (ram_rdata | (one_row << a_idx));
  assign ram_re    = cmd.edge_rd_a | cmd.edge_wr_a | cmd.rd_i | cmd.rd_j;
  assign ram_raddr = cmd.edge_rd_a ? a_idx :
                     cmd.edge_wr_a ? b_idx :
                     cmd.rd_i      ? i     : j;

  fcd_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.load_cnt) begin
      active <= cnt_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_edge) begin
      a_idx <= a_m1[AW-1:0];
      b_idx <= b_m1[AW-1:0];
    end
    if (cmd.q_start) begin
      i <= '0;
    end else if (cmd.next_i) begin
      i <= i + AW'(1);
    end
    if (cmd.load_cnt) begin
      j <= '0;
    end else if (cmd.ld_i) begin
      j <= i + AW'(1);
    end else if (cmd.next_j) begin
      j <= j + AW'(1);
    end
    if (cmd.ld_i) begin
      row_i <= ram_rdata;
    end
    if (cmd.q_start) begin
      hit <= 1'b0;
    end else if (cmd.set_hit) begin
      hit <= 1'b1;
    end
    if (cmd.res_load) begin
      res <= hit;
    end
  end

  assign has_square = res;

endmodule

`default_nettype wire

/* rtl/core/fcd_ctrl.sv */
// ----------------------------------------------------------------------------
// fcd_ctrl
// Controller: sequences row clearing, edge read-modify-write, the pair
// search, and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_ctrl import fcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_command,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output fcd_cmd_t         cmd,
  input  fcd_sts_t         sts
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_CLR     = 4'd1;
  localparam logic [3:0] ST_EDGE_RA = 4'd2;
  localparam logic [3:0] ST_EDGE_WA = 4'd3;
  localparam logic [3:0] ST_EDGE_WB = 4'd4;
  localparam logic [3:0] ST_Q_RI    = 4'd5;
  localparam logic [3:0] ST_Q_LI    = 4'd6;
  localparam logic [3:0] ST_Q_RJ    = 4'd7;
  localparam logic [3:0] ST_Q_CK    = 4'd8;
  localparam logic [3:0] ST_PUB     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_command)
            CMD_START: begin
              cmd.load_cnt = 1'b1;
              if (!sts.cnt_zero) begin
                state_next = ST_CLR;
              end
            end
            CMD_EDGE: begin
              cmd.load_edge = 1'b1;
              if (sts.edge_ok) begin
                state_next = ST_EDGE_RA;
              end
            end
            CMD_QUERY: begin
              cmd.q_start = 1'b1;
              state_next  = sts.few_vtx ? ST_PUB : ST_Q_RI;
            end
            default: ;
          endcase
        end
      end
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.j_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.next_j = 1'b1;
        end
      end
      ST_EDGE_RA: begin
        cmd.edge_rd_a = 1'b1;
        state_next    = ST_EDGE_WA;
      end
      ST_EDGE_WA: begin
        cmd.edge_wr_a = 1'b1;
        state_next    = ST_EDGE_WB;
      end
      ST_EDGE_WB: begin
        cmd.edge_wr_b = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_Q_RI: begin
        cmd.rd_i   = 1'b1;
        state_next = ST_Q_LI;
      end
      ST_Q_LI: begin
        cmd.ld_i   = 1'b1;
        state_next = ST_Q_RJ;
      end
      ST_Q_RJ: begin
        cmd.rd_j   = 1'b1;
        state_next = ST_Q_CK;
      end
      ST_Q_CK: begin
        if (sts.pair_hit) begin
          cmd.set_hit = 1'b1;
          state_next  = ST_PUB;
        end else if (sts.j_last) begin
          if (sts.i_last) begin
            state_next = ST_PUB;
          end else begin
            cmd.next_i = 1'b1;
            state_next = ST_Q_RI;
          end
        end else begin
          cmd.next_j = 1'b1;
          state_next = ST_Q_RJ;
        end
      end
      ST_PUB: begin
        // Hold until the result register is free or being drained.
        if (!out_valid || out_ready) begin
          cmd.res_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/four_cycle_detector_unit.sv */
// ----------------------------------------------------------------------------
// four_cycle_detector_unit
// Loads an undirected graph edge by edge and answers whether it holds a
// cycle of four distinct vertices.
// ----------------------------------------------------------------------------
// Channels: request carries command, vertex_count, vertex_a, vertex_b; result
// carries has_square. Each transfer completes when valid and ready are high.
// A start command (vertex count n, saturated at MAX_VERTICES) zeroes rows
// 0..n-1 of the adjacency RAM, one row per cycle, so request is busy until
// the last row is cleared. An edge command does a read-modify-write of both
// endpoint rows over the single write port, busy through its read-a, write-a
// and write-b states, not at all if the edge is out of range or a self-loop.
// A query walks every vertex pair i < j, reading and capturing row i, then
// reading and checking each row j, paced by the RAM's registered read, and
// stops on an early hit; a publish state then loads the result register.
// Only the query produces a transfer on result. The result stays registered
// while the receiver stalls; start and edge commands are still taken, and a
// further query finishes its search and then holds until the pending result
// is taken.
// Reset clears the vertex count to zero; no RAM sweep runs at reset since
// edges are dropped until a start command has cleared the rows in use.
// ----------------------------------------------------------------------------
`default_nettype none

module four_cycle_detector_unit import fcd_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  fcd_in_if.sink    request,
  fcd_out_if.source result
);

  fcd_cmd_t cmd;
  fcd_sts_t sts;

  // Controller: owns both handshakes and the sequencing.
  fcd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (request.valid),
    .in_command (request.command),
    .in_ready   (request.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Datapath: adjacency store, counters and the neighbor test.
  fcd_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .vertex_count (request.vertex_count),
    .vertex_a     (request.vertex_a),
    .vertex_b     (request.vertex_b),
    .has_square   (result.has_square)
  );

endmodule

`default_nettype wire

/* rtl/core/fcd_checker.sv */
// ----------------------------------------------------------------------------
// fcd_checker
// Port-level checks for the graph square detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fcd_checker import fcd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic [CMD_W-1:0] req_command,
  input logic [VTX_W-1:0] req_vertex_count,
  input logic             res_valid,
  input logic             res_ready,
  input logic             res_has_square
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> $stable(res_has_square))
    else $error("result payload changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_command == CMD_START
     && req_vertex_count != '0) |=> !req_ready)
    else $error("request ready during row clearing");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_command == CMD_QUERY)
    |=> !req_ready)
    else $error("request ready right after a query transfer");

endmodule

bind four_cycle_detector_unit fcd_checker u_fcd_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (request.valid),
  .req_ready        (request.ready),
  .req_command      (request.command),
  .req_vertex_count (request.vertex_count),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .res_has_square   (result.has_square)
);

`default_nettype wire
